@@ sv/prac_pkg.sv @@
// Shared types and constants for the point rotation pipeline.
// Holds the angle formats, the CORDIC state record and the degree arctangent table.
// No dependencies.
package prac_pkg;

  localparam int unsigned ANG_W      = 26;        // input angle, Q9.16 degrees
  localparam int unsigned FOLD_W     = ANG_W + 1; // room for one wrap by 360 degrees
  localparam int unsigned XY_W       = 32;        // CORDIC cosine and sine, Q30
  localparam int unsigned Z_W        = 32;        // CORDIC residual angle, Q24 degrees
  localparam int unsigned Z_SHIFT    = 8;         // Q16 degrees to Q24 degrees
  localparam int unsigned FRAC_W     = 30;        // fraction bits of cosine and sine
  localparam int unsigned MAX_STAGES = 32;

  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [FOLD_W-1:0] fold_t;
  typedef logic signed [XY_W-1:0]   xy_t;
  typedef logic signed [Z_W-1:0]    z_t;

  localparam fold_t DEG90  = fold_t'(5898240);
  localparam fold_t DEG180 = fold_t'(11796480);
  localparam fold_t DEG360 = fold_t'(23592960);

  // Reciprocal of the CORDIC gain in Q30.
  localparam xy_t CORDIC_GAIN_Q30 = xy_t'(652032874);

  // atan(2^-i) in degrees, Q24, rounded to nearest.
  localparam z_t ATAN_DEG_Q24 [MAX_STAGES] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
    7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic flip;
    xy_t  x;
    xy_t  y;
    z_t   z;
  } cordic_t;

endpackage

@@ sv/prac_fold.sv @@
// Front end of the rotation pipeline: wraps and folds the angle into [-90, 90]
// degrees, forms the point offsets and seeds the CORDIC. Two register stages.
// Depends on prac_pkg.
module prac_fold #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  prac_pkg::ang_t                angle_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output prac_pkg::cordic_t             st_o,
  output logic [4*COORD_WIDTH+1:0]      side_o
);
  import prac_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam z_t Z90 = z_t'(DEG90) <<< Z_SHIFT;

  // Wrap stage.
  logic                          w_valid_q;
  logic                          w_ready;
  fold_t                         w_ang_d, w_ang_q;
  logic signed [DW-1:0]          w_dx_d, w_dx_q, w_dy_d, w_dy_q;
  logic signed [COORD_WIDTH-1:0] w_cx_q, w_cy_q;

  // Fold stage.
  logic                          f_valid_q;
  logic                          f_ready;
  fold_t                         f_ang;
  logic                          f_flip;
  cordic_t                       f_st_d, f_st_q;
  logic [4*COORD_WIDTH+1:0]      f_side_q;
  z_t                            z_chk;

  always_comb begin
    w_ang_d = fold_t'(angle_i);
    if (w_ang_d > DEG180) begin
      w_ang_d = w_ang_d - DEG360;
    end else if (w_ang_d < -DEG180) begin
      w_ang_d = w_ang_d + DEG360;
    end
  end

  assign w_dx_d = DW'(point_x_i) - DW'(center_x_i);
  assign w_dy_d = DW'(point_y_i) - DW'(center_y_i);

  assign f_ready = ~f_valid_q | ready_i;
  assign w_ready = ~w_valid_q | f_ready;
  assign ready_o = w_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (w_ready) begin
        w_valid_q <= valid_i;
      end
      if (f_ready) begin
        f_valid_q <= w_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && w_ready) begin
      w_ang_q <= w_ang_d;
      w_dx_q  <= w_dx_d;
      w_dy_q  <= w_dy_d;
      w_cx_q  <= center_x_i;
      w_cy_q  <= center_y_i;
    end
  end

  // Past a right angle the CORDIC angle loses a half turn and the result is negated.
  always_comb begin
    f_ang  = w_ang_q;
    f_flip = 1'b0;
    if (f_ang > DEG90) begin
      f_ang  = f_ang - DEG180;
      f_flip = 1'b1;
    end else if (f_ang < -DEG90) begin
      f_ang  = f_ang + DEG180;
      f_flip = 1'b1;
    end
    f_st_d.flip = f_flip;
    f_st_d.x    = CORDIC_GAIN_Q30;
    f_st_d.y    = '0;
    f_st_d.z    = z_t'(f_ang) <<< Z_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (w_valid_q && f_ready) begin
      f_st_q   <= f_st_d;
      f_side_q <= {w_cx_q, w_cy_q, w_dx_q, w_dy_q};
    end
  end

  assign valid_o = f_valid_q;
  assign st_o    = f_st_q;
  assign side_o  = f_side_q;
  assign z_chk   = f_st_q.z;

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid_q |-> (z_chk <= Z90) && (z_chk >= -Z90))
    else $error("folded angle outside plus or minus 90 degrees");

endmodule

@@ sv/prac_cordic_stage.sv @@
// One rotation-mode CORDIC iteration in degrees, with its pipeline register.
// The offsets and center ride along unchanged. Depends on prac_pkg.
module prac_cordic_stage #(
  parameter int unsigned SHIFT  = 0,
  parameter int unsigned SIDE_W = 130
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  prac_pkg::cordic_t st_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output prac_pkg::cordic_t st_o,
  output logic [SIDE_W-1:0] side_o
);
  import prac_pkg::*;

  localparam z_t ATAN = ATAN_DEG_Q24[SHIFT];

  logic        valid_q;
  xy_t         x_in, y_in, xs, ys;
  z_t          z_in;
  cordic_t     st_d, st_q;
  logic [SIDE_W-1:0] side_q;

  assign x_in = st_i.x;
  assign y_in = st_i.y;
  assign z_in = st_i.z;
  assign xs   = x_in >>> SHIFT;
  assign ys   = y_in >>> SHIFT;

  always_comb begin
    st_d.flip = st_i.flip;
    if (!z_in[Z_W-1]) begin
      st_d.x = x_in - ys;
      st_d.y = y_in + xs;
      st_d.z = z_in - ATAN;
    end else begin
      st_d.x = x_in + ys;
      st_d.y = y_in - xs;
      st_d.z = z_in + ATAN;
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      st_q   <= st_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign side_o  = side_q;

endmodule

@@ sv/prac_rotate.sv @@
// Back end of the rotation pipeline: applies cosine and sine to the offsets,
// rounds, adds the center back and saturates. Five register stages.
// Depends on prac_pkg.
module prac_rotate #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  prac_pkg::cordic_t             st_i,
  input  logic [4*COORD_WIDTH+1:0]      side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [COORD_WIDTH-1:0] rotated_x_o,
  output logic signed [COORD_WIDTH-1:0] rotated_y_o,
  output logic                          overflow_o
);
  import prac_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned SIDE_W = 4 * CW + 2;
  localparam int unsigned LO_W  = DW / 2;
  localparam int unsigned HI_W  = DW - LO_W;
  localparam int unsigned PH_W  = XY_W + HI_W;
  localparam int unsigned PL_W  = XY_W + LO_W + 1;
  localparam int unsigned SH_W  = PH_W + 1;
  localparam int unsigned SL_W  = PL_W + 1;
  localparam int unsigned TOT_W = XY_W + DW + 2;
  localparam int unsigned R_W   = TOT_W - FRAC_W + 1;
  localparam logic signed [TOT_W-1:0] RND = TOT_W'(1) <<< (FRAC_W - 1);
  localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  // Handshake chain, first stage first.
  logic n_valid_q, p_valid_q, s1_valid_q, s2_valid_q, o_valid_q;
  logic n_ready, p_ready, s1_ready, s2_ready, o_ready;

  // Unpacked side band.
  logic signed [CW-1:0] in_cx, in_cy;
  logic signed [DW-1:0] in_dx, in_dy;
  xy_t                  in_x, in_y;

  // Stage N: sign fix and operand split.
  xy_t                    n_x_q, n_y_q;
  logic signed [HI_W-1:0] n_dxh_q, n_dyh_q;
  logic [LO_W-1:0]        n_dxl_q, n_dyl_q;
  logic signed [CW-1:0]   n_cx_q, n_cy_q;

  // Stage P: partial products.
  logic signed [PH_W-1:0] p_xdxh_q, p_xdyh_q, p_ydxh_q, p_ydyh_q;
  logic signed [PL_W-1:0] p_xdxl_q, p_xdyl_q, p_ydxl_q, p_ydyl_q;
  logic signed [CW-1:0]   p_cx_q, p_cy_q;

  // Stage S1: high and low sums.
  logic signed [SH_W-1:0] s1_xh_q, s1_yh_q;
  logic signed [SL_W-1:0] s1_xl_q, s1_yl_q;
  logic signed [CW-1:0]   s1_cx_q, s1_cy_q;

  // Stage S2: full dot products with rounding bias.
  logic signed [TOT_W-1:0] s2_tx_q, s2_ty_q;
  logic signed [CW-1:0]    s2_cx_q, s2_cy_q;

  // Stage O: result register.
  logic signed [TOT_W-1:0] o_qx, o_qy;
  logic signed [R_W-1:0]   o_rx, o_ry;
  logic [CW:0]             o_satx, o_saty;
  logic [CW-1:0]           o_x_q, o_y_q;
  logic                    o_ovf_q;

  // Returns the overflow flag above the clamped coordinate.
  function automatic logic [CW:0] saturate(input logic [R_W-1:0] r);
    logic neg;
    logic ovf;
    neg = r[R_W-1];
    ovf = (r[R_W-1:CW-1] != {(R_W-CW+1){neg}});
    if (ovf) begin
      return {1'b1, neg, {(CW-1){~neg}}};
    end
    return {1'b0, r[CW-1:0]};
  endfunction

  assign in_cx = side_i[SIDE_W-1 -: CW];
  assign in_cy = side_i[SIDE_W-CW-1 -: CW];
  assign in_dx = side_i[2*DW-1 -: DW];
  assign in_dy = side_i[DW-1:0];
  assign in_x  = st_i.x;
  assign in_y  = st_i.y;

  assign o_ready  = ~o_valid_q | ready_i;
  assign s2_ready = ~s2_valid_q | o_ready;
  assign s1_ready = ~s1_valid_q | s2_ready;
  assign p_ready  = ~p_valid_q | s1_ready;
  assign n_ready  = ~n_valid_q | p_ready;
  assign ready_o  = n_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q  <= 1'b0;
      p_valid_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (n_ready) begin
        n_valid_q <= valid_i;
      end
      if (p_ready) begin
        p_valid_q <= n_valid_q;
      end
      if (s1_ready) begin
        s1_valid_q <= p_valid_q;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (o_ready) begin
        o_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && n_ready) begin
      n_x_q   <= st_i.flip ? -in_x : in_x;
      n_y_q   <= st_i.flip ? -in_y : in_y;
      n_dxh_q <= in_dx[DW-1 -: HI_W];
      n_dyh_q <= in_dy[DW-1 -: HI_W];
      n_dxl_q <= in_dx[LO_W-1:0];
      n_dyl_q <= in_dy[LO_W-1:0];
      n_cx_q  <= in_cx;
      n_cy_q  <= in_cy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_valid_q && p_ready) begin
      p_xdxh_q <= n_x_q * n_dxh_q;
      p_xdyh_q <= n_x_q * n_dyh_q;
      p_ydxh_q <= n_y_q * n_dxh_q;
      p_ydyh_q <= n_y_q * n_dyh_q;
      p_xdxl_q <= n_x_q * $signed({1'b0, n_dxl_q});
      p_xdyl_q <= n_x_q * $signed({1'b0, n_dyl_q});
      p_ydxl_q <= n_y_q * $signed({1'b0, n_dxl_q});
      p_ydyl_q <= n_y_q * $signed({1'b0, n_dyl_q});
      p_cx_q   <= n_cx_q;
      p_cy_q   <= n_cy_q;
    end
  end

  // x' uses cos*dx + sin*dy, y' uses cos*dy - sin*dx.
  always_ff @(posedge clk_i) begin
    if (p_valid_q && s1_ready) begin
      s1_xh_q <= SH_W'(p_xdxh_q) + SH_W'(p_ydyh_q);
      s1_yh_q <= SH_W'(p_xdyh_q) - SH_W'(p_ydxh_q);
      s1_xl_q <= SL_W'(p_xdxl_q) + SL_W'(p_ydyl_q);
      s1_yl_q <= SL_W'(p_xdyl_q) - SL_W'(p_ydxl_q);
      s1_cx_q <= p_cx_q;
      s1_cy_q <= p_cy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_tx_q <= (TOT_W'(s1_xh_q) <<< LO_W) + TOT_W'(s1_xl_q) + RND;
      s2_ty_q <= (TOT_W'(s1_yh_q) <<< LO_W) + TOT_W'(s1_yl_q) + RND;
      s2_cx_q <= s1_cx_q;
      s2_cy_q <= s1_cy_q;
    end
  end

  assign o_qx   = s2_tx_q >>> FRAC_W;
  assign o_qy   = s2_ty_q >>> FRAC_W;
  assign o_rx   = R_W'(o_qx) + R_W'(s2_cx_q);
  assign o_ry   = R_W'(o_qy) + R_W'(s2_cy_q);
  assign o_satx = saturate(o_rx);
  assign o_saty = saturate(o_ry);

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && o_ready) begin
      o_x_q   <= o_satx[CW-1:0];
      o_y_q   <= o_saty[CW-1:0];
      o_ovf_q <= o_satx[CW] | o_saty[CW];
    end
  end

  assign valid_o     = o_valid_q;
  assign rotated_x_o = o_x_q;
  assign rotated_y_o = o_y_q;
  assign overflow_o  = o_ovf_q;

  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_ovf_q) |->
      (o_x_q == MAXC) || (o_x_q == MINC) || (o_y_q == MAXC) || (o_y_q == MINC))
    else $error("overflow flagged without a clamped coordinate");

endmodule

@@ sv/point_rotate_about_center_top.sv @@
// Rotates a point about a center by an angle in degrees, positive angles
// turning clockwise. Fully pipelined: one item per clock cycle while the
// output is not stalled, through the wrap and fold stages of angle folding,
// one CORDIC iteration per stage, then multiply, round, recenter and saturate.
// Stalls at the output only hold the input off once every stage is occupied.
module point_rotate_about_center_top #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned CORDIC_STAGES = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  prac_pkg::ang_t                angle_deg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] rotated_x_o,
  output logic signed [COORD_WIDTH-1:0] rotated_y_o,
  output logic                          overflow_o
);
  import prac_pkg::*;

  localparam int unsigned N_ST   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int unsigned SIDE_W = 4 * COORD_WIDTH + 2;

  logic [N_ST:0]     vld;
  logic [N_ST:0]     rdy;
  cordic_t           st   [N_ST+1];
  logic [SIDE_W-1:0] side [N_ST+1];

  prac_fold #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .center_x_i(center_x_i),
    .center_y_i(center_y_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .angle_i   (angle_deg_i),
    .valid_o   (vld[0]),
    .ready_i   (rdy[0]),
    .st_o      (st[0]),
    .side_o    (side[0])
  );

  for (genvar i = 0; i < N_ST; i++) begin : g_cordic
    prac_cordic_stage #(
      .SHIFT (i),
      .SIDE_W(SIDE_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[i]),
      .ready_o(rdy[i]),
      .st_i   (st[i]),
      .side_i (side[i]),
      .valid_o(vld[i+1]),
      .ready_i(rdy[i+1]),
      .st_o   (st[i+1]),
      .side_o (side[i+1])
    );
  end

  prac_rotate #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld[N_ST]),
    .ready_o    (rdy[N_ST]),
    .st_i       (st[N_ST]),
    .side_i     (side[N_ST]),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .rotated_x_o(rotated_x_o),
    .rotated_y_o(rotated_y_o),
    .overflow_o (overflow_o)
  );

  // Back pressure reaches the input only when the output is holding an item.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output item");

endmodule
